FILE: sv/sit_pkg.sv
// Shared types for the segment intersection test pipeline.
// No dependencies.
package sit_pkg;

  // Orientation of an ordered point triple.
  typedef enum logic [1:0] {
    ORI_COLL = 2'd0,
    ORI_CW   = 2'd1,
    ORI_CCW  = 2'd2
  } ori_t;

  localparam int unsigned NUM_ORI = 4;  // o1..o4
  localparam int unsigned NUM_PTS = 4;  // a start, a end, b start, b end
  localparam int unsigned OUT_BYTES_BITS = 8;

endpackage

FILE: sv/segment_intersection_test.sv
// Top level of the segment intersection test: a four-stage streaming pipeline.
// Depends on sit_pkg.
//
// Decides whether two closed 2-D segments A (a_start -> a_end) and B
// (b_start -> b_end) intersect or touch. One transaction may enter every
// clock cycle while s_tready is high. A result is presented on m_tvalid
// once it has passed through all four register stages, which in order
// are: coordinate differences and bounding-box tests, the eight
// cross-product multiplies (all in one stage, each 2*(COORD_BITS+1) bits
// wide), the product compares that give the four orientations, and the
// final decision, which is also the output register. Each stage holds its
// own valid bit and advances when the next stage is empty or moving, so a
// stalled output fills bubbles behind it before s_tready drops.
// Coordinates are two's complement, COORD_BITS wide each.
module segment_intersection_test #(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  // s_tdata fields, lowest bit up: a_start_x, a_start_y, a_end_x, a_end_y,
  // b_start_x, b_start_y, b_end_x, b_end_y (COORD_BITS each)
  input  logic [8*COORD_BITS-1:0]   s_tdata,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // m_tdata fields, lowest bit up: crosses (1 bit), zero fill to one byte
  output logic [sit_pkg::OUT_BYTES_BITS-1:0] m_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready
);
  import sit_pkg::*;

  localparam int DW = COORD_BITS + 1;     // difference width
  localparam int PW = 2 * COORD_BITS + 2; // product width

  // Point triple (p, q, r) per orientation; r is also the box-tested point.
  localparam int P_IDX [NUM_ORI] = '{0, 0, 2, 2};
  localparam int Q_IDX [NUM_ORI] = '{1, 1, 3, 3};
  localparam int R_IDX [NUM_ORI] = '{2, 3, 0, 1};

  // Stage handshake
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4 || m_tready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_tready = rdy1;

  // Input unpack
  logic signed [COORD_BITS-1:0] px [NUM_PTS];
  logic signed [COORD_BITS-1:0] py [NUM_PTS];

  always_comb begin
    for (int j = 0; j < NUM_PTS; j++) begin
      px[j] = $signed(s_tdata[(2*j)*COORD_BITS +: COORD_BITS]);
      py[j] = $signed(s_tdata[(2*j+1)*COORD_BITS +: COORD_BITS]);
    end
  end

  // Stage 1: differences and box tests
  // lhs = (qy-py)*(rx-qx), rhs = (qx-px)*(ry-qy)
  logic signed [DW-1:0] dl0_next [NUM_ORI];
  logic signed [DW-1:0] dl1_next [NUM_ORI];
  logic signed [DW-1:0] dr0_next [NUM_ORI];
  logic signed [DW-1:0] dr1_next [NUM_ORI];
  logic [NUM_ORI-1:0]   box_next;

  always_comb begin
    for (int k = 0; k < NUM_ORI; k++) begin
      dl0_next[k] = DW'(py[Q_IDX[k]]) - DW'(py[P_IDX[k]]);
      dl1_next[k] = DW'(px[R_IDX[k]]) - DW'(px[Q_IDX[k]]);
      dr0_next[k] = DW'(px[Q_IDX[k]]) - DW'(px[P_IDX[k]]);
      dr1_next[k] = DW'(py[R_IDX[k]]) - DW'(py[Q_IDX[k]]);
      // r inside the closed box of p and q
      box_next[k] =
        (px[R_IDX[k]] <= px[P_IDX[k]] || px[R_IDX[k]] <= px[Q_IDX[k]]) &&
        (px[R_IDX[k]] >= px[P_IDX[k]] || px[R_IDX[k]] >= px[Q_IDX[k]]) &&
        (py[R_IDX[k]] <= py[P_IDX[k]] || py[R_IDX[k]] <= py[Q_IDX[k]]) &&
        (py[R_IDX[k]] >= py[P_IDX[k]] || py[R_IDX[k]] >= py[Q_IDX[k]]);
    end
  end

  logic signed [DW-1:0] dl0 [NUM_ORI];
  logic signed [DW-1:0] dl1 [NUM_ORI];
  logic signed [DW-1:0] dr0 [NUM_ORI];
  logic signed [DW-1:0] dr1 [NUM_ORI];
  logic [NUM_ORI-1:0]   box1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_tvalid;
    end
    if (rdy1 && s_tvalid) begin
      dl0  <= dl0_next;
      dl1  <= dl1_next;
      dr0  <= dr0_next;
      dr1  <= dr1_next;
      box1 <= box_next;
    end
  end

  // Stage 2: exact cross products
  logic signed [PW-1:0] lhs [NUM_ORI];
  logic signed [PW-1:0] rhs [NUM_ORI];
  logic [NUM_ORI-1:0]   box2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      for (int k = 0; k < NUM_ORI; k++) begin
        lhs[k] <= PW'(dl0[k]) * PW'(dl1[k]);
        rhs[k] <= PW'(dr0[k]) * PW'(dr1[k]);
      end
      box2 <= box1;
    end
  end

  // Stage 3: orientation codes
  ori_t ori_next [NUM_ORI];

  always_comb begin
    for (int k = 0; k < NUM_ORI; k++) begin
      if (lhs[k] == rhs[k]) begin
        ori_next[k] = ORI_COLL;
      end else if (lhs[k] > rhs[k]) begin
        ori_next[k] = ORI_CW;
      end else begin
        ori_next[k] = ORI_CCW;
      end
    end
  end

  ori_t               ori [NUM_ORI];
  logic [NUM_ORI-1:0] box3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3 && v2) begin
      ori  <= ori_next;
      box3 <= box2;
    end
  end

  // Stage 4: decision, output register
  logic crosses_next;
  logic crosses;

  always_comb begin
    crosses_next = (ori[0] != ori[1]) && (ori[2] != ori[3]);
    for (int k = 0; k < NUM_ORI; k++) begin
      if (ori[k] == ORI_COLL && box3[k]) begin
        crosses_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
    if (rdy4 && v3) begin
      crosses <= crosses_next;
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = {{(OUT_BYTES_BITS-1){1'b0}}, crosses};

endmodule

FILE: sv/sit_checker.sv
// Port-level checker for segment_intersection_test, with its bind statement.
// Depends on the top level's ports only.
module sit_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic [7:0] m_tdata,
  input logic       m_tvalid,
  input logic       m_tready
);

  // Pipeline comes out of reset empty.
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  // Input backpressure only when the output is held and stalled.
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("s_tready low with output free");

  // Held result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // Fill bits of the result byte are zero.
  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:1] == 7'd0))
    else $error("m_tdata fill bits nonzero");

endmodule

bind segment_intersection_test sit_checker u_sit_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

FILE: verif/segment_intersection_test_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for segment_intersection_test: directed and random segment pairs.
// Depends on sit_pkg and the segment_intersection_test RTL; needs no other files.
module segment_intersection_test_test;
  import sit_pkg::*;

  localparam int COORD_BITS = 16;
  localparam int PAIR_BITS = 8 * COORD_BITS;
  localparam int ITEMS_PER_PHASE = 585;     // three idling phases, ~1750 random pairs
  localparam int CYCLE_LIMIT = 400000;      // far above the slowest legal run
  localparam int DRAIN_CYCLES = 12;         // pipeline is four stages deep
  localparam int HOLD_CYCLES = 120;         // long output stall in the last phase

  typedef logic [PAIR_BITS-1:0] pair_t;

  // Tracks the verdicts still owed by the block and compares each one that arrives.
  class crossing_board;
    typedef struct {
      pair_t pair;
      bit    crosses;
    } verdict_t;

    verdict_t owed[$];
    int       mismatches;

    function automatic ori_t turn(longint px, longint py, longint qx, longint qy,
                                  longint rx, longint ry);
      longint lhs;
      longint rhs;
      lhs = (qy - py) * (rx - qx);
      rhs = (qx - px) * (ry - qy);
      if (lhs == rhs) return ORI_COLL;
      return (lhs > rhs) ? ORI_CW : ORI_CCW;
    endfunction

    // q lies in the closed bounding box spanned by p and r
    function automatic bit boxed(longint px, longint py, longint qx, longint qy,
                                 longint rx, longint ry);
      return qx <= ((px > rx) ? px : rx) && qx >= ((px < rx) ? px : rx) &&
             qy <= ((py > ry) ? py : ry) && qy >= ((py < ry) ? py : ry);
    endfunction

    function automatic bit intersects(pair_t d);
      longint c[8];
      ori_t   o1, o2, o3, o4;
      for (int i = 0; i < 8; i++)
        c[i] = longint'($signed(d[COORD_BITS*i +: COORD_BITS]));
      // c: 0/1 a start, 2/3 a end, 4/5 b start, 6/7 b end
      o1 = turn(c[0], c[1], c[2], c[3], c[4], c[5]);
      o2 = turn(c[0], c[1], c[2], c[3], c[6], c[7]);
      o3 = turn(c[4], c[5], c[6], c[7], c[0], c[1]);
      o4 = turn(c[4], c[5], c[6], c[7], c[2], c[3]);
      if (o1 != o2 && o3 != o4) return 1'b1;
      // collinear endpoint touching the other segment
      if (o1 == ORI_COLL && boxed(c[0], c[1], c[4], c[5], c[2], c[3])) return 1'b1;
      if (o2 == ORI_COLL && boxed(c[0], c[1], c[6], c[7], c[2], c[3])) return 1'b1;
      if (o3 == ORI_COLL && boxed(c[4], c[5], c[0], c[1], c[6], c[7])) return 1'b1;
      if (o4 == ORI_COLL && boxed(c[4], c[5], c[2], c[3], c[6], c[7])) return 1'b1;
      return 1'b0;
    endfunction

    function void note_pair(pair_t d);
      verdict_t v;
      v.pair = d;
      v.crosses = intersects(d);
      owed.insert(owed.size(), v);
    endfunction

    function void check_verdict(logic [OUT_BYTES_BITS-1:0] data);
      verdict_t v;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected result %h with nothing outstanding", data);
        return;
      end
      v = owed.pop_front();
      if (data[0] !== v.crosses || data[OUT_BYTES_BITS-1:1] !== '0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: pair %h expected crosses=%0b fill=0, got crosses=%b fill=%h",
                   v.pair, v.crosses, data[0], data[OUT_BYTES_BITS-1:1]);
      end
    endfunction

    function int outstanding();
      return owed.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst = 1'b1;
  logic [PAIR_BITS-1:0]      s_tdata = '0;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [OUT_BYTES_BITS-1:0] m_tdata;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;

  crossing_board board = new();

  int send_idle_pct = 30;
  int recv_idle_pct = 55;
  int phase = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  segment_intersection_test #(
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),   // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, ... b_end_y
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata (m_tdata),   // crosses, zero fill
    .m_tvalid(m_tvalid),
    .m_tready(m_tready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: nothing should ever take this long.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // Output side: check each transaction, then pick the next tready.
  // In the last phase it stalls for a long stretch once so the pipeline
  // backs up and s_tready has to drop while the sender keeps offering.
  initial begin
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) board.check_verdict(m_tdata);
      if (phase == 2 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic pair_t pack(int ax, int ay, int bx, int by,
                                 int cx, int cy, int dx, int dy);
    int    v[8];
    pair_t d;
    v = '{ax, ay, bx, by, cx, cy, dx, dy};
    for (int i = 0; i < 8; i++) d[COORD_BITS*i +: COORD_BITS] = v[i][COORD_BITS-1:0];
    return d;
  endfunction

  // Random pair: mix of raw noise, tiny grids, collinear points, shared
  // endpoints and extreme values, so touching and collinear cases show up often.
  function automatic pair_t random_pair();
    int    kind, bx, by, ux, uy, k, src, dst;
    int    v[8];
    int    extremes[7];
    extremes = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 8; i++) v[i] = int'($urandom);
    if (kind < 30) begin
      // raw 16-bit noise already in place
    end else if (kind < 55) begin
      for (int i = 0; i < 8; i++) v[i] = int'($urandom_range(0, 12)) - 6;
    end else if (kind < 75) begin
      bx = int'($urandom_range(0, 40000)) - 20000;
      by = int'($urandom_range(0, 40000)) - 20000;
      ux = int'($urandom_range(0, 4000)) - 2000;
      uy = int'($urandom_range(0, 4000)) - 2000;
      for (int j = 0; j < 4; j++) begin
        k = int'($urandom_range(0, 8)) - 4;
        v[2*j] = bx + k * ux;
        v[2*j+1] = by + k * uy;
      end
    end else if (kind < 90) begin
      if ($urandom_range(0, 1) == 1)
        for (int i = 0; i < 8; i++) v[i] = int'($urandom_range(0, 200)) - 100;
      src = $urandom_range(0, 1);
      dst = 2 + $urandom_range(0, 1);
      v[2*dst] = v[2*src];
      v[2*dst+1] = v[2*src+1];
    end else begin
      for (int i = 0; i < 8; i++)
        if ($urandom_range(0, 3) != 0) v[i] = extremes[$urandom_range(0, 6)];
    end
    return pack(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
  endfunction

  // Offer one pair, with random idle cycles ahead of it, until it is taken.
  task automatic send_pair(pair_t d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    board.note_pair(d);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pairs
    send_pair(pack(0, 0, 0, 0, 0, 0, 0, 0));                    // all points coincide
    send_pair(pack(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pair(pack(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(pack(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(pack(0, 0, 10, 0, 0, 1, 10, 1));                  // parallel, apart
    send_pair(pack(0, 0, 10, 0, 5, 0, 15, 0));                  // collinear overlap
    send_pair(pack(0, 0, 4, 0, 5, 0, 9, 0));                    // collinear gap
    send_pair(pack(0, 0, 5, 5, 5, 5, 10, 0));                   // shared endpoint
    send_pair(pack(0, 0, 10, 0, 5, -5, 5, 0));                  // T junction
    send_pair(pack(0, 0, 10, 0, 5, -5, 5, -1));                 // T that falls short
    send_pair(pack(3, 3, 3, 3, 0, 0, 6, 6));                    // point segment on B
    send_pair(pack(3, 4, 3, 4, 0, 0, 6, 6));                    // point segment off B
    send_pair(pack(7, -7, 7, -7, 7, -7, 7, -7));                // both points, same
    send_pair(pack(7, -7, 7, -7, -7, 7, -7, 7));                // both points, apart
    send_pair(pack(-32768, -32768, 32767, 32767, -32768, -32767, 32767, 32766));
    send_pair(pack(-32768, 0, 0, 0, 0, 0, 32767, 0));           // collinear, touching
    send_pair(pack(0, -32768, 0, 32767, 0, -5, 0, 5));          // vertical containment
    send_pair(pack(0, 0, 2, 2, 3, 3, 5, 5));                    // same line, beyond box
    send_pair(pack(0, 0, 4, 4, 0, 4, 4, 0));                    // plain cross
    send_pair(pack(4, 4, 0, 0, 4, 0, 0, 4));                    // same, reversed ends
    send_pair(pack(-1, -1, 0, 0, 0, -1, -1, 0));                // around the sign change

    for (int p = 0; p < 3; p++) begin
      if (p > 0) begin
        // let earlier results drain before the idling pattern changes
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0) @(posedge clk);
      end
      case (p)
        0: begin send_idle_pct = 30; recv_idle_pct = 55; end
        1: begin send_idle_pct = 55; recv_idle_pct = 30; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      phase = p;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_pair(random_pair());
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
